### rtl/tfn_pkg.sv
// Package for the triangle face normal pipeline: widths, stage counts and the
// sideband structs that travel beside the arithmetic. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int CoordW   = 16;  // Q8.8 corner coordinate
  localparam int EdgeW    = 17;  // exact edge component
  localparam int ProdW    = 34;  // edge product
  localparam int CrossW   = 35;  // cross component
  localparam int MagW     = 34;  // cross magnitude
  localparam int ShiftW   = 4;   // normalizing shift, 0..10
  localparam int NormW    = 24;  // normalized magnitude
  localparam int SqW      = 48;  // square of a normalized magnitude
  localparam int SumW     = 50;  // sum of three squares
  localparam int RadFracW = 12;  // radicand scale, root comes out in units of 2^-6
  localparam int RadW     = SumW + RadFracW;
  localparam int RootW    = 31;
  localparam int SqStages = RootW;  // one root bit per stage
  localparam int SqResW   = RadW + 1;
  localparam int NumShift = 21;
  localparam int NumW     = NormW + NumShift + 1;
  localparam int DivW     = RootW + 1;
  localparam int QuotW    = 15;   // quotient never exceeds one in Q1.14
  localparam int OutW     = 16;
  localparam int IndexW   = 16;
  localparam logic [QuotW-1:0] Unit = QuotW'(16384);

  typedef struct packed {
    logic [IndexW-1:0]        triangle;
    logic                     degen;
    logic [2:0]               neg;
    logic [2:0][NormW-1:0]    mag;
  } norm_tag_t;

  typedef struct packed {
    logic [IndexW-1:0] triangle;
    logic              degen;
    logic [2:0]        neg;
  } div_tag_t;

endpackage

`default_nettype wire

### rtl/tfn_sqrt.sv
// Pipelined integer square root, one root bit per stage, for the length stage.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [tfn_pkg::RadW-1:0] radicand,
  input  tfn_pkg::norm_tag_t       in_tag,
  output logic                     out_valid,
  output logic [tfn_pkg::RootW-1:0] root,
  output tfn_pkg::norm_tag_t       out_tag
);
  import tfn_pkg::*;

  logic [RadW-1:0]   rem_q [0:SqStages];
  logic [SqResW-1:0] res_q [0:SqStages];
  norm_tag_t         tag_q [0:SqStages];
  logic              vld_q [0:SqStages];

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= radicand;
      res_q[0] <= '0;
      tag_q[0] <= in_tag;
    end
  end

  for (genvar j = 0; j < SqStages; j++) begin : g_step
    localparam int Sh = 2 * (SqStages - 1 - j);
    logic [SqResW-1:0] trial;
    logic              take;

    assign trial = res_q[j] + (SqResW'(1) << Sh);
    assign take  = ({1'b0, rem_q[j]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else if (en) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[j+1] <= tag_q[j];
        if (take) begin
          rem_q[j+1] <= rem_q[j] - trial[RadW-1:0];
          res_q[j+1] <= (res_q[j] >> 1) + (SqResW'(1) << Sh);
        end else begin
          rem_q[j+1] <= rem_q[j];
          res_q[j+1] <= res_q[j] >> 1;
        end
      end
    end
  end

  assign out_valid = vld_q[SqStages];
  assign root      = res_q[SqStages][RootW-1:0];
  assign out_tag   = tag_q[SqStages];

endmodule

`default_nettype wire

### rtl/tfn_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage; rounds to nearest. Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [2:0][tfn_pkg::NormW-1:0]   mag,
  input  logic [tfn_pkg::RootW-1:0]        root,
  input  tfn_pkg::div_tag_t                in_tag,
  output logic                             out_valid,
  output logic [2:0][tfn_pkg::QuotW-1:0]   quot,
  output tfn_pkg::div_tag_t                out_tag
);
  import tfn_pkg::*;

  logic [2:0][NumW-1:0]  rem_q [0:QuotW];
  logic [2:0][QuotW-1:0] q_q   [0:QuotW];
  logic [DivW-1:0]       dv_q  [0:QuotW];
  div_tag_t              tag_q [0:QuotW];
  logic                  vld_q [0:QuotW];

  // numerator = mag * 2^21 + root, divisor = 2 * root
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= (NumW'(mag[k]) << NumShift) + NumW'(root);
      end
      q_q[0]   <= '0;
      dv_q[0]  <= {root, 1'b0};
      tag_q[0] <= in_tag;
    end
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_step
    localparam int Bit = QuotW - 1 - j;
    logic [NumW-1:0] shifted;

    assign shifted = NumW'(dv_q[j]) << Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else if (en) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j+1]  <= dv_q[j];
        tag_q[j+1] <= tag_q[j];
        for (int k = 0; k < 3; k++) begin
          if (rem_q[j][k] >= shifted) begin
            rem_q[j+1][k]    <= rem_q[j][k] - shifted;
            q_q[j+1][k]      <= q_q[j][k] | (QuotW'(1) << Bit);
          end else begin
            rem_q[j+1][k]    <= rem_q[j][k];
            q_q[j+1][k]      <= q_q[j][k];
          end
        end
      end
    end
  end

  assign out_valid = vld_q[QuotW];
  assign quot      = q_q[QuotW];
  assign out_tag   = tag_q[QuotW];

endmodule

`default_nettype wire

### rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg, tfn_sqrt and tfn_div.
`timescale 1ns / 1ps
`default_nettype none

// Unit face normal of one triangle per transfer. Corners come in as signed
// Q8.8; the block forms edge1 = second - first and edge2 = third - first, takes
// their exact cross product, scales the largest magnitude below 2^24, and
// divides each component by the rounded-down length (sqrt of the sum of
// squares) with round-to-nearest. The normal leaves as signed Q1.14 in
// -16384..16384, with the triangle index echoed (the normal belongs to
// vertices 3i..3i+2). A zero cross product sets degenerate and returns a zero
// vector. Throughput is one triangle per clock unless a result is held. The
// pipe has seven front stages (edges, products, cross, magnitude, shift
// select, shift, squares), 32 square root stages (sum register plus one root
// bit per stage), 16 divider stages (numerator setup plus one quotient bit per
// stage) and the output register. The whole pipe moves together and halts only
// while a result is held on the output under stall; item_stall mirrors that.
module triangle_face_normal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [tfn_pkg::IndexW-1:0]        triangle_index,
  input  logic signed [tfn_pkg::CoordW-1:0] first_x,
  input  logic signed [tfn_pkg::CoordW-1:0] first_y,
  input  logic signed [tfn_pkg::CoordW-1:0] first_z,
  input  logic signed [tfn_pkg::CoordW-1:0] second_x,
  input  logic signed [tfn_pkg::CoordW-1:0] second_y,
  input  logic signed [tfn_pkg::CoordW-1:0] second_z,
  input  logic signed [tfn_pkg::CoordW-1:0] third_x,
  input  logic signed [tfn_pkg::CoordW-1:0] third_y,
  input  logic signed [tfn_pkg::CoordW-1:0] third_z,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [tfn_pkg::IndexW-1:0]        result_triangle,
  output logic signed [tfn_pkg::OutW-1:0]   normal_x,
  output logic signed [tfn_pkg::OutW-1:0]   normal_y,
  output logic signed [tfn_pkg::OutW-1:0]   normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  // global advance: everything moves unless the output is held
  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // front valid chain, stages 1..7
  logic [7:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], item_valid};
    end
  end

  logic [IndexW-1:0] tri_q [1:7];

  // stage 1: edges
  logic signed [EdgeW-1:0] e1 [0:2];
  logic signed [EdgeW-1:0] e2 [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[1] <= triangle_index;
      e1[0] <= EdgeW'(second_x) - EdgeW'(first_x);
      e1[1] <= EdgeW'(second_y) - EdgeW'(first_y);
      e1[2] <= EdgeW'(second_z) - EdgeW'(first_z);
      e2[0] <= EdgeW'(third_x) - EdgeW'(first_x);
      e2[1] <= EdgeW'(third_y) - EdgeW'(first_y);
      e2[2] <= EdgeW'(third_z) - EdgeW'(first_z);
    end
  end

  // stage 2: six products
  logic signed [ProdW-1:0] pr [0:5];
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[2] <= tri_q[1];
      pr[0] <= ProdW'(e1[1]) * ProdW'(e2[2]);
      pr[1] <= ProdW'(e1[2]) * ProdW'(e2[1]);
      pr[2] <= ProdW'(e1[2]) * ProdW'(e2[0]);
      pr[3] <= ProdW'(e1[0]) * ProdW'(e2[2]);
      pr[4] <= ProdW'(e1[0]) * ProdW'(e2[1]);
      pr[5] <= ProdW'(e1[1]) * ProdW'(e2[0]);
    end
  end

  // stage 3: cross product
  logic signed [CrossW-1:0] cr [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[3] <= tri_q[2];
      for (int k = 0; k < 3; k++) begin
        cr[k] <= CrossW'(pr[2*k]) - CrossW'(pr[2*k+1]);
      end
    end
  end

  // stage 4: magnitudes, signs, zero test
  logic [MagW-1:0] mg4 [0:2];
  logic [2:0]      neg_q [4:7];
  logic            zero_q [4:7];
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[4]  <= tri_q[3];
      zero_q[4] <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      for (int k = 0; k < 3; k++) begin
        neg_q[4][k] <= cr[k][CrossW-1];
        mg4[k]      <= cr[k][CrossW-1] ? MagW'(-cr[k]) : MagW'(cr[k]);
      end
    end
  end

  // stage 5: largest magnitude -> shift that brings it below 2^24
  logic [MagW-1:0]   big;
  logic [ShiftW-1:0] sh_next;
  always_comb begin
    big = mg4[0];
    if (mg4[1] > big) big = mg4[1];
    if (mg4[2] > big) big = mg4[2];
    sh_next = '0;
    for (int i = NormW; i < MagW; i++) begin
      if (big[i]) sh_next = ShiftW'(i - NormW + 1);
    end
  end

  logic [MagW-1:0]   mg5 [0:2];
  logic [ShiftW-1:0] sh;
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[5]  <= tri_q[4];
      neg_q[5]  <= neg_q[4];
      zero_q[5] <= zero_q[4];
      mg5       <= mg4;
      sh        <= sh_next;
    end
  end

  // stage 6: normalized magnitudes
  logic [2:0][NormW-1:0] an6;
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[6]  <= tri_q[5];
      neg_q[6]  <= neg_q[5];
      zero_q[6] <= zero_q[5];
      for (int k = 0; k < 3; k++) begin
        an6[k] <= NormW'(mg5[k] >> sh);
      end
    end
  end

  // stage 7: squares
  logic [2:0][NormW-1:0] an7;
  logic [SqW-1:0]        sq [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[7]  <= tri_q[6];
      neg_q[7]  <= neg_q[6];
      zero_q[7] <= zero_q[6];
      an7       <= an6;
      for (int k = 0; k < 3; k++) begin
        sq[k] <= SqW'(an6[k]) * SqW'(an6[k]);
      end
    end
  end

  // sum of squares, registered at the root's entry stage
  logic [SumW-1:0] sum;
  logic [RadW-1:0] radicand;
  norm_tag_t       sq_tag;
  assign sum      = SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
  assign radicand = {sum, {RadFracW{1'b0}}};
  assign sq_tag   = '{triangle: tri_q[7], degen: zero_q[7], neg: neg_q[7], mag: an7};

  logic                  rt_valid;
  logic [RootW-1:0]      rt_root;
  norm_tag_t             rt_tag;

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[7]),
    .radicand  (radicand),
    .in_tag    (sq_tag),
    .out_valid (rt_valid),
    .root      (rt_root),
    .out_tag   (rt_tag)
  );

  div_tag_t              dv_in_tag;
  logic                  dv_valid;
  logic [2:0][QuotW-1:0] dv_quot;
  div_tag_t              dv_tag;
  assign dv_in_tag = '{triangle: rt_tag.triangle, degen: rt_tag.degen, neg: rt_tag.neg};

  tfn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_valid),
    .mag       (rt_tag.mag),
    .root      (rt_root),
    .in_tag    (dv_in_tag),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_tag   (dv_tag)
  );

  // output: clamp to one, apply sign, zero on degenerate
  logic signed [OutW-1:0] nrm_next [0:2];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [QuotW-1:0] qs;
      qs = (dv_quot[k] > Unit) ? Unit : dv_quot[k];
      if (dv_tag.degen) begin
        nrm_next[k] = '0;
      end else if (dv_tag.neg[k]) begin
        nrm_next[k] = -OutW'(qs);
      end else begin
        nrm_next[k] = OutW'(qs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_triangle <= dv_tag.triangle;
      degenerate      <= dv_tag.degen;
      normal_x        <= nrm_next[0];
      normal_y        <= nrm_next[1];
      normal_z        <= nrm_next[2];
    end
  end

  // a degenerate result carries a zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // components never leave the unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
                  && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
                  && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal component out of range");

  // the input side halts exactly when a result is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("input stall out of step with output hold");

  // a held result does not vanish
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("held result dropped");

endmodule

`default_nettype wire
